// ===== rtl/core/dnsa_pkg.sv =====
// dnsa_pkg: shared constants and types for the dns answer address parser
// used by dnsa_parse, dnsa_outq and parse_dns_answer_addresses; no dependencies
package dnsa_pkg;

    // sizing
    localparam int MAX_ADDRS         = 5;
    localparam int MAX_MESSAGE_BYTES = 1024;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int FOUND_W           = $clog2(MAX_ADDRS + 1);
    localparam int OFFSET_W          = 10;
    localparam int CMP_W             = ((POS_W > OFFSET_W) ? POS_W : OFFSET_W) + 1;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one result word
    typedef struct packed {
        logic        is_summary;
        logic [31:0] address;
        logic [31:0] ttl_seconds;
        logic [2:0]  address_count;
        logic [1:0]  status;
    } t_result;

    // results produced by one message byte, in delivery order
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== rtl/core/dnsa_parse.sv =====
// dnsa_parse: input register and byte-serial dns response parser
// depends on dnsa_pkg; hands up to two result words per byte to the queue
module dnsa_parse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [9:0]                i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_msg_byte,
    input  logic                      i_last,
    input  logic                      i_space_ok,
    output dnsa_pkg::t_push           o_push
);
    import dnsa_pkg::*;

    // parse phases
    localparam logic [3:0] PH_HEADER   = 4'd0;
    localparam logic [3:0] PH_SKIP     = 4'd1;
    localparam logic [3:0] PH_NAME_LEN = 4'd2;
    localparam logic [3:0] PH_LABEL    = 4'd3;
    localparam logic [3:0] PH_PTR_LOW  = 4'd4;
    localparam logic [3:0] PH_TYPE     = 4'd5;
    localparam logic [3:0] PH_CLASS    = 4'd6;
    localparam logic [3:0] PH_TTL      = 4'd7;
    localparam logic [3:0] PH_RDLEN    = 4'd8;
    localparam logic [3:0] PH_ADDR     = 4'd9;
    localparam logic [3:0] PH_DATA     = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FLAGS = 2'd1;
    localparam logic [1:0] ST_TRUNC     = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    // protocol constants
    localparam logic [15:0]       FLAG_MASK    = 16'hF9FF;
    localparam logic [15:0]       FLAG_OK      = 16'h8180;
    localparam logic [15:0]       TYPE_A       = 16'h0001;
    localparam logic [1:0]        PTR_MARK     = 2'b11;
    localparam logic [OFFSET_W-1:0] HEADER_BYTES = OFFSET_W'(12);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             consume;

    // config register
    logic [OFFSET_W-1:0] r_answer_offset;

    // parser state
    logic [POS_W-1:0]   r_pos,      n_pos;
    logic [3:0]         r_phase,    n_phase;
    logic [15:0]        r_flags,    n_flags;
    logic [15:0]        r_ans_left, n_ans_left;
    logic [15:0]        r_skip,     n_skip;
    logic [31:0]        r_acc,      n_acc;
    logic [15:0]        r_rtype,    n_rtype;
    logic [31:0]        r_last_ttl, n_last_ttl;
    logic [FOUND_W-1:0] r_found,    n_found;
    logic [1:0]         r_err,      n_err;
    logic [2:0]         r_fleft,    n_fleft;

    logic [OFFSET_W-1:0] start;
    logic                addr_hit;
    logic [1:0]          sum_status;
    t_result             addr_res;
    t_result             sum_res;

    assign consume = r_in_valid && i_space_ok;
    assign o_stall = r_in_valid && !i_space_ok;
    assign start   = (r_answer_offset < HEADER_BYTES) ? HEADER_BYTES : r_answer_offset;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && !o_stall) begin
            r_in_byte <= i_msg_byte;
            r_in_last <= i_last;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_answer_offset <= HEADER_BYTES;
        end else if (i_cfg_wr_en) begin
            r_answer_offset <= i_cfg_wr_data;
        end
    end

    // next state for one message byte
    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_ans_left = r_ans_left;
        n_skip     = r_skip;
        n_acc      = r_acc;
        n_rtype    = r_rtype;
        n_last_ttl = r_last_ttl;
        n_found    = r_found;
        n_err      = r_err;
        n_fleft    = r_fleft;
        addr_hit   = 1'b0;
        addr_res   = '0;

        if (r_pos < POS_W'(MAX_MESSAGE_BYTES)) begin
            n_pos = r_pos + POS_W'(1);

            // field bytes shift into the accumulator
            if (r_phase inside {PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN, PH_ADDR}) begin
                n_acc   = {r_acc[23:0], r_in_byte};
                n_fleft = (r_fleft != 3'd0) ? r_fleft - 3'd1 : 3'd0;
            end

            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(2)) n_flags = {r_in_byte, 8'h00};
                    if (r_pos == POS_W'(3) &&
                            (({r_flags[15:8], r_in_byte} & FLAG_MASK) != FLAG_OK)) begin
                        n_flags = {r_flags[15:8], r_in_byte};
                        n_err   = ST_BAD_FLAGS;
                        n_phase = PH_DONE;
                    end else begin
                        if (r_pos == POS_W'(3)) n_flags = {r_flags[15:8], r_in_byte};
                        if (r_pos == POS_W'(6)) n_ans_left = {r_in_byte, 8'h00};
                        if (r_pos == POS_W'(7)) n_ans_left = {r_ans_left[15:8], r_in_byte};
                        if (r_pos == POS_W'(11)) begin
                            if (r_ans_left == 16'd0) n_phase = PH_DONE;
                            else if (start <= HEADER_BYTES) n_phase = PH_NAME_LEN;
                            else n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (CMP_W'(r_pos) + CMP_W'(1) >= CMP_W'(start)) n_phase = PH_NAME_LEN;
                end
                PH_NAME_LEN: begin
                    if (r_in_byte == 8'd0) begin
                        n_phase = PH_TYPE;
                        n_fleft = 3'd2;
                        n_acc   = '0;
                    end else if (r_in_byte[7:6] == PTR_MARK) begin
                        n_phase = PH_PTR_LOW;
                    end else begin
                        n_skip  = {8'h00, r_in_byte};
                        n_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    n_skip = (r_skip != 16'd0) ? r_skip - 16'd1 : 16'd0;
                    if (n_skip == 16'd0) n_phase = PH_NAME_LEN;
                end
                PH_PTR_LOW: begin
                    n_phase = PH_TYPE;
                    n_fleft = 3'd2;
                    n_acc   = '0;
                end
                PH_TYPE: begin
                    if (n_fleft == 3'd0) begin
                        n_rtype = n_acc[15:0];
                        n_phase = PH_CLASS;
                        n_fleft = 3'd2;
                        n_acc   = '0;
                    end
                end
                PH_CLASS: begin
                    if (n_fleft == 3'd0) begin
                        n_phase = PH_TTL;
                        n_fleft = 3'd4;
                        n_acc   = '0;
                    end
                end
                PH_TTL: begin
                    if (n_fleft == 3'd0) begin
                        if (r_rtype == TYPE_A) n_last_ttl = n_acc;
                        n_phase = PH_RDLEN;
                        n_fleft = 3'd2;
                        n_acc   = '0;
                    end
                end
                PH_RDLEN: begin
                    if (n_fleft == 3'd0) begin
                        if (r_rtype == TYPE_A) begin
                            if (n_acc[15:0] < 16'd4) begin
                                n_err   = ST_MALFORMED;
                                n_phase = PH_DONE;
                            end else begin
                                n_skip  = n_acc[15:0] - 16'd4;
                                n_phase = PH_ADDR;
                                n_fleft = 3'd4;
                                n_acc   = '0;
                            end
                        end else if (n_acc[15:0] == 16'd0) begin
                            n_ans_left = r_ans_left - 16'd1;
                            n_phase    = (n_ans_left == 16'd0) ? PH_DONE : PH_NAME_LEN;
                        end else begin
                            n_skip  = n_acc[15:0];
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_ADDR: begin
                    if (n_fleft == 3'd0) begin
                        n_found                = r_found + FOUND_W'(1);
                        addr_hit               = 1'b1;
                        addr_res.is_summary    = 1'b0;
                        addr_res.address       = n_acc;
                        addr_res.ttl_seconds   = r_last_ttl;
                        addr_res.address_count = 3'(n_found);
                        addr_res.status        = ST_OK;
                        if (n_found >= FOUND_W'(MAX_ADDRS)) begin
                            n_phase = PH_DONE;
                        end else if (r_skip == 16'd0) begin
                            n_ans_left = r_ans_left - 16'd1;
                            n_phase    = (n_ans_left == 16'd0) ? PH_DONE : PH_NAME_LEN;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_skip = (r_skip != 16'd0) ? r_skip - 16'd1 : 16'd0;
                    if (n_skip == 16'd0) begin
                        n_ans_left = r_ans_left - 16'd1;
                        n_phase    = (n_ans_left == 16'd0) ? PH_DONE : PH_NAME_LEN;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // end-of-message summary
    always_comb begin
        sum_status = ((n_err == ST_OK) && (n_phase != PH_DONE)) ? ST_TRUNC : n_err;
        sum_res               = '0;
        sum_res.is_summary    = 1'b1;
        sum_res.address       = 32'd0;
        sum_res.ttl_seconds   = n_last_ttl;
        sum_res.address_count = 3'(n_found);
        sum_res.status        = sum_status;
    end

    // words handed to the result queue, address word first
    always_comb begin
        o_push = '0;
        if (consume) begin
            if (addr_hit) begin
                o_push.first  = addr_res;
                o_push.second = sum_res;
                o_push.num    = r_in_last ? 2'd2 : 2'd1;
            end else if (r_in_last) begin
                o_push.first = sum_res;
                o_push.num   = 2'd1;
            end
        end
    end

    // parser state registers; a message end returns everything to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (consume && r_in_last)) begin
            r_pos      <= '0;
            r_phase    <= PH_HEADER;
            r_flags    <= '0;
            r_ans_left <= '0;
            r_skip     <= '0;
            r_acc      <= '0;
            r_rtype    <= '0;
            r_last_ttl <= '0;
            r_found    <= '0;
            r_err      <= ST_OK;
            r_fleft    <= '0;
        end else if (consume) begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_ans_left <= n_ans_left;
            r_skip     <= n_skip;
            r_acc      <= n_acc;
            r_rtype    <= n_rtype;
            r_last_ttl <= n_last_ttl;
            r_found    <= n_found;
            r_err      <= n_err;
            r_fleft    <= n_fleft;
        end
    end

endmodule

// ===== rtl/core/dnsa_outq.sv =====
// dnsa_outq: small result queue, two writes and one read per cycle
// depends on dnsa_pkg; feeds the output word channel
module dnsa_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dnsa_pkg::t_push   i_push,
    output logic              o_space_ok,
    output logic              o_valid,
    input  logic              i_stall,
    output dnsa_pkg::t_result o_result
);
    import dnsa_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    assign o_valid    = (r_count != '0);
    assign pop        = o_valid && !i_stall;
    assign o_result   = r_mem[r_rd_ptr];
    // room for the two words one byte may produce
    assign o_space_ok = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.second;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.num);
            if (pop) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= r_count + QCNT_W'(i_push.num) - QCNT_W'(pop);
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.num != 2'd0) |->
            ((QCNT_W + 1)'(r_count) + (QCNT_W + 1)'(i_push.num) <=
             (QCNT_W + 1)'(QUEUE_DEPTH)))
        else $error("result queue written while full");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_push.num == 2'd0)) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("result queue count not reduced by read");
`endif

endmodule

// ===== rtl/core/parse_dns_answer_addresses.sv =====
// parse_dns_answer_addresses: byte-serial dns response parser giving a-record words
// a byte waits in the input register until the queue has room, then its words enter the queue
// throughput: one byte per cycle; the output stalls input once the four-word queue holds three
// reset: i_rst_n synchronous, active low; answer_offset returns to 12, parser to header phase
// depends on dnsa_pkg, dnsa_parse and dnsa_outq
module parse_dns_answer_addresses (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [9:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_summary,
    output logic [31:0] o_address,
    output logic [31:0] o_ttl_seconds,
    output logic [2:0]  o_address_count,
    output logic [1:0]  o_status
);
    import dnsa_pkg::*;

    t_push   push;
    t_result result;
    logic    space_ok;

    // parser with input register
    dnsa_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_msg_byte    (i_msg_byte),
        .i_last        (i_last),
        .i_space_ok    (space_ok),
        .o_push        (push)
    );

    // result word queue
    dnsa_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (result)
    );

    // output word fields
    assign o_is_summary    = result.is_summary;
    assign o_address       = result.address;
    assign o_ttl_seconds   = result.ttl_seconds;
    assign o_address_count = result.address_count;
    assign o_status        = result.status;

endmodule

// ===== dv/parse_dns_answer_addresses_test.sv =====
// parse_dns_answer_addresses_test: self-checking bench for the dns answer address parser
// holds its own byte-serial parser model, directed and random replies, random idling
// depends on dnsa_pkg and parse_dns_answer_addresses
`timescale 1ns / 1ps

module parse_dns_answer_addresses_test;
    import dnsa_pkg::*;

    // status codes and protocol constants
    localparam logic [1:0]  ST_OK         = 2'd0;
    localparam logic [1:0]  ST_BAD_FLAGS  = 2'd1;
    localparam logic [1:0]  ST_TRUNCATED  = 2'd2;
    localparam logic [1:0]  ST_MALFORMED  = 2'd3;
    localparam logic [15:0] TYPE_A        = 16'h0001;
    localparam logic [15:0] FLAG_MASK     = 16'hF9FF;
    localparam logic [15:0] FLAG_GOOD     = 16'h8180;
    localparam logic [7:0]  POINTER_MARK  = 8'hC0;
    localparam int          HEADER_BYTES  = 12;
    localparam int          TAIL_CYCLES   = 8;
    localparam int          PHASE_BYTES   = 80;
    localparam int          CYCLE_LIMIT   = 500000;

    typedef enum logic [3:0] {
        WALK_HEADER, WALK_QUESTION, WALK_NAME_LEN, WALK_LABEL, WALK_PTR_LOW, WALK_TYPE,
        WALK_CLASS, WALK_TTL, WALK_RDLEN, WALK_ADDR, WALK_DATA, WALK_DONE
    } t_walk;

    // one directed row: the word sent and, where pinned, the words it must give
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [1:0] npin;
        t_result    w0;
        t_result    w1;
    } t_row;

    localparam t_result NO_WORD = '0;

    // after reset a lone final byte, then failing flags, then one a-record reply
    // whose flags carry the ignored bits and whose ttl and address are all ones
    localparam t_row DIRECTED [33] = '{
        '{8'h00, 1'b1, 2'd1, '{1'b1, 32'd0, 32'd0, 3'd0, ST_TRUNCATED}, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b1, 2'd1, '{1'b1, 32'd0, 32'd0, 3'd0, ST_BAD_FLAGS}, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h87, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h80, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h01, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h01, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hC0, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h0C, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h01, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h01, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h00, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'h04, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{8'hFF, 1'b1, 2'd2,
          '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1, ST_OK},
          '{1'b1, 32'd0, 32'hFFFF_FFFF, 3'd1, ST_OK}}
    };

    // block ports
    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [9:0]  i_cfg_wr_data   = '0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [7:0]  i_msg_byte      = '0;
    logic        i_last          = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic        o_is_summary;
    logic [31:0] o_address;
    logic [31:0] o_ttl_seconds;
    logic [2:0]  o_address_count;
    logic [1:0]  o_status;

    // parser model state
    logic [9:0]  answer_offset;
    logic [10:0] msg_pos;
    t_walk       walk;
    logic [15:0] hdr_flags;
    logic [15:0] answers_left;
    logic [15:0] skip_left;
    logic [31:0] field_acc;
    logic [15:0] rec_type;
    logic [31:0] a_ttl;
    logic [2:0]  addr_found;
    logic [1:0]  reply_status;
    logic [2:0]  field_left;
    t_result     parsed_words [2];

    // bench bookkeeping
    t_result     pending_words [$];
    logic [7:0]  reply [$];
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          cycle_count = 0;

    parse_dns_answer_addresses DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_msg_byte      (i_msg_byte),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_is_summary    (o_is_summary),
        .o_address       (o_address),
        .o_ttl_seconds   (o_ttl_seconds),
        .o_address_count (o_address_count),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void clear_message();
        msg_pos      = '0;
        walk         = WALK_HEADER;
        hdr_flags    = '0;
        answers_left = '0;
        skip_left    = '0;
        field_acc    = '0;
        rec_type     = '0;
        a_ttl        = '0;
        addr_found   = '0;
        reply_status = ST_OK;
        field_left   = '0;
    endfunction

    function automatic void open_field(t_walk next, logic [2:0] nbytes);
        walk       = next;
        field_left = nbytes;
        field_acc  = '0;
    endfunction

    function automatic void close_record();
        answers_left = answers_left - 16'd1;
        if (answers_left == 0)
            walk = WALK_DONE;
        else
            walk = WALK_NAME_LEN;
    endfunction

    // advance the parser model by one byte; returns how many result words it gave
    function automatic int parse_reply_byte(logic [7:0] b, logic fin);
        int          n;
        int          first_answer;
        logic [15:0] rdlen;
        logic [1:0]  st;
        n = 0;
        first_answer = (answer_offset < HEADER_BYTES) ? HEADER_BYTES : int'(answer_offset);
        if (msg_pos < MAX_MESSAGE_BYTES) begin
            // fixed-size fields shift in big-endian
            if (walk inside {WALK_TYPE, WALK_CLASS, WALK_TTL, WALK_RDLEN, WALK_ADDR}) begin
                field_acc = {field_acc[23:0], b};
                if (field_left != 0)
                    field_left = field_left - 3'd1;
            end
            case (walk)
                WALK_HEADER: begin
                    if (msg_pos == 2)
                        hdr_flags = {b, 8'h00};
                    if (msg_pos == 3) begin
                        hdr_flags[7:0] = b;
                        if ((hdr_flags & FLAG_MASK) != FLAG_GOOD) begin
                            reply_status = ST_BAD_FLAGS;
                            walk = WALK_DONE;
                        end
                    end
                    if (walk == WALK_HEADER) begin
                        if (msg_pos == 6)
                            answers_left = {b, 8'h00};
                        if (msg_pos == 7)
                            answers_left[7:0] = b;
                        if (msg_pos == HEADER_BYTES - 1) begin
                            if (answers_left == 0)
                                walk = WALK_DONE;
                            else if (first_answer <= HEADER_BYTES)
                                walk = WALK_NAME_LEN;
                            else
                                walk = WALK_QUESTION;
                        end
                    end
                end
                WALK_QUESTION: begin
                    if (int'(msg_pos) + 1 >= first_answer)
                        walk = WALK_NAME_LEN;
                end
                WALK_NAME_LEN: begin
                    if (b == 8'h00)
                        open_field(WALK_TYPE, 3'd2);
                    else if ((b & POINTER_MARK) == POINTER_MARK)
                        walk = WALK_PTR_LOW;
                    else begin
                        skip_left = {8'h00, b};
                        walk = WALK_LABEL;
                    end
                end
                WALK_LABEL: begin
                    if (skip_left != 0)
                        skip_left = skip_left - 16'd1;
                    if (skip_left == 0)
                        walk = WALK_NAME_LEN;
                end
                WALK_PTR_LOW: open_field(WALK_TYPE, 3'd2);
                WALK_TYPE: begin
                    if (field_left == 0) begin
                        rec_type = field_acc[15:0];
                        open_field(WALK_CLASS, 3'd2);
                    end
                end
                WALK_CLASS: begin
                    if (field_left == 0)
                        open_field(WALK_TTL, 3'd4);
                end
                WALK_TTL: begin
                    if (field_left == 0) begin
                        if (rec_type == TYPE_A)
                            a_ttl = field_acc;
                        open_field(WALK_RDLEN, 3'd2);
                    end
                end
                WALK_RDLEN: begin
                    if (field_left == 0) begin
                        rdlen = field_acc[15:0];
                        if (rec_type == TYPE_A) begin
                            if (rdlen < 4) begin
                                reply_status = ST_MALFORMED;
                                walk = WALK_DONE;
                            end else begin
                                skip_left = rdlen - 16'd4;
                                open_field(WALK_ADDR, 3'd4);
                            end
                        end else if (rdlen == 0) begin
                            close_record();
                        end else begin
                            skip_left = rdlen;
                            walk = WALK_DATA;
                        end
                    end
                end
                WALK_ADDR: begin
                    if (field_left == 0) begin
                        addr_found = addr_found + 3'd1;
                        parsed_words[n] = '{1'b0, field_acc, a_ttl, addr_found, ST_OK};
                        n++;
                        if (addr_found >= MAX_ADDRS)
                            walk = WALK_DONE;
                        else if (skip_left == 0)
                            close_record();
                        else
                            walk = WALK_DATA;
                    end
                end
                WALK_DATA: begin
                    if (skip_left != 0)
                        skip_left = skip_left - 16'd1;
                    if (skip_left == 0)
                        close_record();
                end
                default: walk = WALK_DONE;
            endcase
            msg_pos = msg_pos + 11'd1;
        end
        // the final byte closes the reply with a summary
        if (fin) begin
            st = reply_status;
            if (st == ST_OK && walk != WALK_DONE)
                st = ST_TRUNCATED;
            parsed_words[n] = '{1'b1, 32'd0, a_ttl, addr_found, st};
            n++;
            clear_message();
        end
        return n;
    endfunction

    function automatic void push_random(int count);
        repeat (count) reply.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_pointer();
        reply.push_back(POINTER_MARK | 8'($urandom_range(0, 63)));
        push_random(1);
    endfunction

    // one answer record: name, type, class, ttl, data length and data
    function automatic void add_record();
        int          labels;
        int          len;
        logic [15:0] rt;
        logic [15:0] rdlen;
        case ($urandom_range(0, 3))
            0: push_pointer();
            1: reply.push_back(8'h00);
            default: begin
                labels = $urandom_range(1, 3);
                repeat (labels) begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 63) :
                                                         $urandom_range(1, 6);
                    reply.push_back(8'(len));
                    push_random(len);
                end
                if ($urandom_range(0, 1) == 1)
                    push_pointer();
                else
                    reply.push_back(8'h00);
            end
        endcase
        rt = ($urandom_range(0, 3) != 0) ? TYPE_A : 16'($urandom());
        reply.push_back(rt[15:8]);
        reply.push_back(rt[7:0]);
        push_random(6);
        if (rt == TYPE_A) begin
            case ($urandom_range(0, 9))
                0:       rdlen = 16'($urandom_range(0, 3));
                1:       rdlen = 16'($urandom_range(5, 8));
                default: rdlen = 16'd4;
            endcase
        end else begin
            rdlen = 16'($urandom_range(0, 8));
        end
        reply.push_back(rdlen[15:8]);
        reply.push_back(rdlen[7:0]);
        push_random(int'(rdlen));
    endfunction

    // mostly well-formed replies, some cut short, some noise, some with bad flags
    function automatic void build_reply();
        int          shape;
        int          first_answer;
        int          cut;
        logic [15:0] count;
        reply = {};
        shape = $urandom_range(0, 9);
        if (shape == 8) begin
            push_random($urandom_range(1, 40));
            return;
        end
        push_random(2);
        if (shape == 9) begin
            push_random(2);
        end else begin
            reply.push_back(8'h81 | 8'($urandom_range(0, 3) << 1));
            reply.push_back(8'h80);
        end
        push_random(2);
        count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(8, 65535)) :
                                              16'($urandom_range(0, 7));
        reply.push_back(count[15:8]);
        reply.push_back(count[7:0]);
        push_random(4);
        first_answer = (answer_offset < HEADER_BYTES) ? HEADER_BYTES : int'(answer_offset);
        push_random(first_answer - HEADER_BYTES);
        for (int r = 0; r < int'(count) && r < 8; r++)
            add_record();
        if ($urandom_range(0, 7) == 0)
            push_random($urandom_range(1, 3));
        if (shape == 7) begin
            cut = $urandom_range(1, reply.size() - 1);
            while (reply.size() > cut)
                void'(reply.pop_back());
        end
    endfunction

    // present one message byte after a random gap and hold it until taken
    task automatic send_word(input logic [7:0] b, input logic fin);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_msg_byte <= b;
        i_last     <= fin;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_reply();
        int n;
        calm = ($urandom_range(0, 4) == 0);
        foreach (reply[i]) begin
            send_word(reply[i], i == reply.size() - 1);
            n = parse_reply_byte(reply[i], i == reply.size() - 1);
            for (int k = 0; k < n; k++)
                pending_words.push_back(parsed_words[k]);
        end
    endtask

    // wait for every expected word, then let the pipeline run empty
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: random stall before each word, then check it
    initial begin
        int      hold;
        t_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (pending_words.size() == 0) begin
                $error("unexpected word: summary %0d address 0x%0h status %0d",
                       o_is_summary, o_address, o_status);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                cmp_field("is_summary", 32'(want.is_summary), 32'(o_is_summary));
                cmp_field("address", want.address, o_address);
                cmp_field("ttl_seconds", want.ttl_seconds, o_ttl_seconds);
                cmp_field("address_count", 32'(want.address_count), 32'(o_address_count));
                cmp_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    // stimulus side
    initial begin
        logic [9:0] offsets [6];
        int         n;
        int         phase_bytes;
        answer_offset = 10'd12;
        clear_message();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i].data, DIRECTED[i].fin);
            n = parse_reply_byte(DIRECTED[i].data, DIRECTED[i].fin);
            if (DIRECTED[i].npin == 0) begin
                for (int k = 0; k < n; k++)
                    pending_words.push_back(parsed_words[k]);
            end else begin
                pending_words.push_back(DIRECTED[i].w0);
                if (DIRECTED[i].npin == 2)
                    pending_words.push_back(DIRECTED[i].w1);
            end
        end

        // random replies under several answer offsets, written while idle
        offsets = '{10'd0, 10'd1023, 10'd12, 10'($urandom_range(13, 40)), 10'd13,
                    10'($urandom_range(12, 40))};
        foreach (offsets[p]) begin
            settle();
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= offsets[p];
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b0;
            answer_offset = offsets[p];
            if (offsets[p] == 10'd1023) begin
                // one reply running past the parsed length, then short ones
                do build_reply(); while (reply.size() <= MAX_MESSAGE_BYTES);
                send_reply();
                repeat (2) begin
                    do build_reply(); while (reply.size() > 60);
                    send_reply();
                end
            end else begin
                phase_bytes = 0;
                while (phase_bytes < PHASE_BYTES) begin
                    build_reply();
                    send_reply();
                    phase_bytes += reply.size();
                end
            end
        end

        settle();
        if (mismatches == 0 && pending_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== parse_dns_answer_addresses.f =====
rtl/core/dnsa_pkg.sv
rtl/core/dnsa_parse.sv
rtl/core/dnsa_outq.sv
rtl/core/parse_dns_answer_addresses.sv
dv/parse_dns_answer_addresses_test.sv
